/* sv/bmp_stream_to_rgb565_decoder_macros.svh */
// Assertion helpers used by the checker file.
`ifndef BMP_STREAM_TO_RGB565_DECODER_MACROS_SVH
`define BMP_STREAM_TO_RGB565_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMP565_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bmp565 assertion failed");

// Next-cycle implication, disabled during reset.
`define BMP565_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bmp565 assertion failed");

`endif

/* sv/bmp565_pkg.sv */
// ----------------------------------------------------------------------------
// bmp565_pkg
// Types, register indexes and helpers shared by the BMP to RGB565 decoder.
// ----------------------------------------------------------------------------
package bmp565_pkg;

    localparam int REG_IDX_W = 3;
    localparam int CFG_DW    = 16;

    localparam logic [REG_IDX_W-1:0] REG_DEST_X        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEST_Y        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MODE   = 3'd4;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // crop window coordinates (cover offsets up to 32768)
    localparam int WIN_W = 17;

    typedef struct packed {
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic        output_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        ENT_STATUS = 2'd0,
        ENT_RGB    = 2'd1,
        ENT_MONO   = 2'd2
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t   kind;
        logic        status;
        logic        done;    // done on the last pixel of this request
        logic [11:0] x;       // column of first pixel (mono: bit 7)
        logic [11:0] y;
        logic [15:0] color;
        logic [7:0]  bits;    // raw mono byte, MSB first
        logic [7:0]  mask;    // mono pixels inside window, index 0 = MSB
        logic        raw;     // memory mode: emit raw bit
        logic [15:0] pal0;
        logic [15:0] pal1;
    } entry_t;

    function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        to565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

/* sv/bmp_stream_to_rgb565_decoder.sv */
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_decoder
// Streaming BMP (1-bit / 24-bit) to RGB565 pixel decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) carries one file byte per request;
//    first_byte marks byte 0 of a file and restarts the parse.
//  - Output channel (out_valid / out_stall) carries one pixel or one status
//    result per request, in file order; done_res flags the last one.
//  - Config registers (wr_en, wr_index, wr_data) are sampled at first_byte;
//    write them only while the block is idle.
//  - Throughput: one byte per cycle. A 1-bit byte expands into up to 8
//    pixels, one per cycle through the back end unless the output stalls,
//    so the input stalls while the 4-entry request queue is full.
//  - A result passes through the request queue and the output register.
//  - Output stall holds the output register; the queue keeps taking bytes
//    until it fills, then in_stall rises.
//  - Reset clears the parser to waiting for first_byte, empties the queue
//    and loads the register defaults (screen 320 x 240, screen mode).
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb565_decoder #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [bmp565_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [bmp565_pkg::CFG_DW-1:0]       wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          file_byte,
    input  logic                                first_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pixel_valid,
    output logic [11:0]                         pixel_x,
    output logic [11:0]                         pixel_y,
    output logic [15:0]                         color,
    output logic                                status,
    output logic                                done_res
);

    bmp565_pkg::cfg_t   cfg_reg, cfg_next;
    bmp565_pkg::entry_t push_data, head;
    logic               push, pop, head_valid, q_full, take;

    // config register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                bmp565_pkg::REG_DEST_X:        cfg_next.dest_x = wr_data;
                bmp565_pkg::REG_DEST_Y:        cfg_next.dest_y = wr_data;
                bmp565_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width = wr_data[12:0];
                bmp565_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = wr_data[12:0];
                bmp565_pkg::REG_OUTPUT_MODE:   cfg_next.output_mode = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_x        <= 16'd0;
            cfg_reg.dest_y        <= 16'd0;
            cfg_reg.screen_width  <= 13'd320;
            cfg_reg.screen_height <= 13'd240;
            cfg_reg.output_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a byte is taken whenever the queue has room
    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    bmp565_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (take),
        .file_byte  (file_byte),
        .first_byte (first_byte),
        .push       (push),
        .push_data  (push_data)
    );

    bmp565_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    bmp565_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color       (color),
        .status      (status),
        .done_res    (done_res)
    );

endmodule

/* sv/bmp565_queue.sv */
// ----------------------------------------------------------------------------
// bmp565_queue
// Small register FIFO of decoded requests between front and back.
// ----------------------------------------------------------------------------
module bmp565_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bmp565_pkg::entry_t  push_data,
    input  logic                pop,
    output bmp565_pkg::entry_t  head,
    output logic                head_valid,
    output logic                full
);

    bmp565_pkg::entry_t                  q_reg [bmp565_pkg::QDEPTH];
    logic [bmp565_pkg::QPTR_W-1:0]       wptr_reg, wptr_next;
    logic [bmp565_pkg::QPTR_W-1:0]       rptr_reg, rptr_next;
    logic [bmp565_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                                do_push, do_pop;

    function automatic logic [bmp565_pkg::QCNT_W-1:0] QCNT_W1(input logic b);
        QCNT_W1 = {{(bmp565_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign full       = (cnt_reg == bmp565_pkg::QCNT_W'(bmp565_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W1(do_push) - QCNT_W1(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* sv/bmp565_front.sv */
// ----------------------------------------------------------------------------
// bmp565_front
// Header parser and pixel-data walker: one file byte per cycle while take is
// high, at most one request per byte into the queue.
// ----------------------------------------------------------------------------
module bmp565_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bmp565_pkg::cfg_t    cfg,
    input  logic                take,
    input  logic [7:0]          file_byte,
    input  logic                first_byte,
    output logic                push,
    output bmp565_pkg::entry_t  push_data
);

    localparam int DW  = $clog2(MAX_DIM + 1);  // image dimension
    localparam int CW  = DW + 1;               // column counter
    localparam int RBW = DW + 2;               // bytes per row
    localparam int XW  = bmp565_pkg::WIN_W + 1;

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_PRE  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] sig_reg, sig_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [31:0] wid_reg, wid_next;
    logic [31:0] hgt_reg, hgt_next;
    logic        bu_reg, bu_next;
    logic [15:0] depth_reg, depth_next;
    logic [15:0] planes_reg, planes_next;
    logic [31:0] comp_reg, comp_next;
    logic [15:0] pal0_reg, pal0_next;
    logic [15:0] pal1_reg, pal1_next;
    logic        mode_reg, mode_next;
    logic [15:0] latx_reg, latx_next;
    logic [15:0] laty_reg, laty_next;
    logic [12:0] latsw_reg, latsw_next;
    logic [12:0] latsh_reg, latsh_next;
    logic [bmp565_pkg::WIN_W-1:0] c0_reg, c0_next, c1_reg, c1_next;
    logic [bmp565_pkg::WIN_W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [15:0] offx_reg, offx_next, offy_reg, offy_next;
    logic [DW-1:0]  lastf_reg, lastf_next;
    logic [RBW-1:0] rb_reg, rb_next;
    logic        mono_reg, mono_next;
    logic [DW-1:0]  row_reg, row_next;
    logic [RBW-1:0] bir_reg, bir_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [1:0]  k_reg, k_next;
    logic [15:0] part_reg, part_next;

    // ---------------- header finish ----------------
    logic [31:0] acc_sh;
    logic [15:0] fh_depth;
    logic [33:0] need_pal, need_pos;
    logic        fh_bad, fh_empty;
    logic signed [19:0] lx, ly, sw20, sh20, w20, h20;
    logic signed [19:0] fc0, fx0, flw1, flw, fr0, fy0, flh1, flh;
    logic signed [19:0] fc1, fr1, flast;
    logic [DW+5:0]  rb_bits;
    logic [RBW-1:0] fh_rb;

    assign acc_sh = {file_byte, acc_reg[31:8]};

    always_comb
    begin
        fh_depth = (pos_reg == 32'd29) ? acc_sh[31:16] : depth_reg;
        need_pal = 34'd14 + 34'(hdr_reg) + ((fh_depth == 16'd1) ? 34'd8 : 34'd0);
        need_pos = 34'(pos_reg) + 34'd1;
        fh_bad = (sig_reg != bmp565_pkg::BMP_SIGNATURE) || (planes_reg != 16'd1)
              || (comp_reg != 32'd0) || ((fh_depth != 16'd1) && (fh_depth != 16'd24))
              || (wid_reg > 32'(MAX_DIM)) || (hgt_reg > 32'(MAX_DIM))
              || (34'(off_reg) < need_pal) || (34'(off_reg) < need_pos);

        lx   = 20'(signed'(latx_reg));
        ly   = 20'(signed'(laty_reg));
        sw20 = signed'(20'(latsw_reg));
        sh20 = signed'(20'(latsh_reg));
        w20  = signed'(20'(wid_reg[DW-1:0]));
        h20  = signed'(20'(hgt_reg[DW-1:0]));
        if (!mode_reg)
        begin
            fc0  = lx[19] ? -lx : 20'sd0;
            fx0  = lx[19] ? 20'sd0 : lx;
            flw1 = w20 - fc0;
            flw  = (fx0 + flw1 > sw20) ? sw20 - fx0 : flw1;
            fr0  = ly[19] ? -ly : 20'sd0;
            fy0  = ly[19] ? 20'sd0 : ly;
            flh1 = h20 - fr0;
            flh  = (fy0 + flh1 > sh20) ? sh20 - fy0 : flh1;
        end
        else
        begin
            fc0  = 20'sd0;
            fx0  = 20'sd0;
            flw1 = w20;
            flw  = w20;
            fr0  = 20'sd0;
            fy0  = 20'sd0;
            flh1 = h20;
            flh  = h20;
        end
        fh_empty = flw[19] || (flw == 20'sd0) || flh[19] || (flh == 20'sd0);
        fc1   = fc0 + flw - 20'sd1;
        fr1   = fr0 + flh - 20'sd1;
        flast = bu_reg ? h20 - 20'sd1 - fr0 : fr1;
        if (fh_depth == 16'd1)
        begin
            rb_bits = (DW+6)'(wid_reg[DW-1:0]) + (DW+6)'(31);
        end
        else
        begin
            rb_bits = ((DW+6)'(wid_reg[DW-1:0]) << 4) + ((DW+6)'(wid_reg[DW-1:0]) << 3)
                    + (DW+6)'(31);
        end
        fh_rb = RBW'({rb_bits[DW+5:5], 2'b00});
    end

    // ---------------- palette capture ----------------
    logic [32:0] pbase, pd;
    logic        pcap;

    always_comb
    begin
        pbase = 33'd14 + 33'(hdr_reg);
        pd    = 33'(pos_reg) - pbase;
        pcap  = (pos_reg >= 32'd18) && (33'(pos_reg) >= pbase) && (pd < 33'd8);
    end

    // ---------------- pixel data ----------------
    logic           entering;
    logic [DW-1:0]  row_e, rowr;
    logic [RBW-1:0] bir_e;
    logic [CW-1:0]  col_e;
    logic [1:0]     k_e;
    logic [RBW:0]   bir_inc;
    logic           wrap, r_in, rgb_rng, rgb_pix, rgb_in, d_fin, d_push;
    logic [XW-1:0]  ci [8];
    logic [7:0]     mmask, meq;
    logic [11:0]    px;

    always_comb
    begin
        entering = (phase_reg == PH_PRE);
        row_e = entering ? '0 : row_reg;
        bir_e = entering ? '0 : bir_reg;
        col_e = entering ? '0 : col_reg;
        k_e   = entering ? 2'd0 : k_reg;
        rowr  = bu_reg ? hgt_reg[DW-1:0] - DW'(1) - row_e : row_e;
        r_in  = (bmp565_pkg::WIN_W'(rowr) >= r0_reg) && (bmp565_pkg::WIN_W'(rowr) <= r1_reg);
        for (int i = 0; i < 8; i++)
        begin
            ci[i]    = XW'(col_e) + XW'(i);
            mmask[i] = (ci[i] < XW'(wid_reg[DW-1:0])) && (ci[i] >= XW'(c0_reg))
                    && (ci[i] <= XW'(c1_reg)) && r_in;
            meq[i]   = (ci[i] == XW'(c1_reg));
        end
        rgb_rng = (XW'(col_e) < XW'(wid_reg[DW-1:0]));
        rgb_pix = rgb_rng && (k_e == 2'd2);
        rgb_in  = rgb_pix && r_in && (XW'(col_e) >= XW'(c0_reg))
               && (XW'(col_e) <= XW'(c1_reg));
        if (mono_reg)
        begin
            d_push = |mmask;
            d_fin  = (row_e == lastf_reg) && |(mmask & meq);
        end
        else
        begin
            d_push = rgb_in;
            d_fin  = rgb_in && (row_e == lastf_reg) && (XW'(col_e) == XW'(c1_reg));
        end
        bir_inc = (RBW+1)'(bir_e) + (RBW+1)'(1);
        wrap    = (bir_inc >= (RBW+1)'(rb_reg));
        px      = 12'(col_e) + offx_reg[11:0];
    end

    // ---------------- state update ----------------
    always_comb
    begin
        phase_next = phase_reg;  pos_next = pos_reg;     acc_next = acc_reg;
        sig_next = sig_reg;      off_next = off_reg;     hdr_next = hdr_reg;
        wid_next = wid_reg;      hgt_next = hgt_reg;     bu_next = bu_reg;
        depth_next = depth_reg;  planes_next = planes_reg; comp_next = comp_reg;
        pal0_next = pal0_reg;    pal1_next = pal1_reg;   mode_next = mode_reg;
        latx_next = latx_reg;    laty_next = laty_reg;
        latsw_next = latsw_reg;  latsh_next = latsh_reg;
        c0_next = c0_reg;  c1_next = c1_reg;  r0_next = r0_reg;  r1_next = r1_reg;
        offx_next = offx_reg;    offy_next = offy_reg;
        lastf_next = lastf_reg;  rb_next = rb_reg;       mono_next = mono_reg;
        row_next = row_reg;      bir_next = bir_reg;     col_next = col_reg;
        k_next = k_reg;          part_next = part_reg;
        push = 1'b0;
        push_data = '0;
        push_data.kind = bmp565_pkg::ENT_STATUS;

        if (take)
        begin
            if (first_byte)
            begin
                mode_next  = cfg.output_mode;
                latx_next  = cfg.dest_x;
                laty_next  = cfg.dest_y;
                latsw_next = cfg.screen_width;
                latsh_next = cfg.screen_height;
                pos_next = 32'd1;     acc_next = {file_byte, 24'd0};
                sig_next = '0;        off_next = '0;   hdr_next = '0;
                wid_next = '0;        hgt_next = '0;   bu_next = 1'b1;
                depth_next = '0;      planes_next = '0; comp_next = '0;
                phase_next = PH_HEAD;
                // window entirely right of or below the screen
                if (!cfg.output_mode
                    && ((signed'(cfg.dest_x) >= signed'({4'd0, cfg.screen_width}))
                     || (signed'(cfg.dest_y) >= signed'({4'd0, cfg.screen_height}))))
                begin
                    phase_next = PH_WAIT;
                    push = 1'b1;
                    push_data.done = 1'b1;
                end
            end
            else
            begin
                if (((phase_reg == PH_HEAD) || ((phase_reg == PH_PRE) && (pos_reg != off_reg)))
                    && pcap)
                begin
                    if (pd[2])
                    begin
                        unique case (pd[1:0])
                            2'd0: pal1_next[4:0]   = file_byte[7:3];
                            2'd1: pal1_next[10:5]  = file_byte[7:2];
                            2'd2: pal1_next[15:11] = file_byte[7:3];
                            default: ;
                        endcase
                    end
                    else
                    begin
                        unique case (pd[1:0])
                            2'd0: pal0_next[4:0]   = file_byte[7:3];
                            2'd1: pal0_next[10:5]  = file_byte[7:2];
                            2'd2: pal0_next[15:11] = file_byte[7:3];
                            default: ;
                        endcase
                    end
                end

                unique case (phase_reg)
                    PH_WAIT: ;
                    PH_HEAD:
                    begin
                        acc_next = acc_sh;
                        pos_next = pos_reg + 32'd1;
                        if ((pos_reg == 32'd1))  sig_next = acc_sh[31:16];
                        if ((pos_reg == 32'd13)) off_next = acc_sh;
                        if ((pos_reg == 32'd17)) hdr_next = acc_sh;
                        if ((pos_reg == 32'd21)) wid_next = acc_sh;
                        if ((pos_reg == 32'd25))
                        begin
                            hgt_next = acc_sh[31] ? (~acc_sh) + 32'd1 : acc_sh;
                            bu_next  = !acc_sh[31];
                        end
                        if ((pos_reg == 32'd27)) planes_next = acc_sh[31:16];
                        if ((pos_reg == 32'd29)) depth_next = acc_sh[31:16];
                        if ((pos_reg == 32'd33)) comp_next = acc_sh;
                        if (((pos_reg == 32'd29) && (hdr_reg <= 32'd12)) || (pos_reg == 32'd53))
                        begin
                            if (fh_bad || fh_empty)
                            begin
                                phase_next = PH_WAIT;
                                push = 1'b1;
                                push_data.status = fh_bad;
                                push_data.done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PRE;
                                c0_next = bmp565_pkg::WIN_W'(fc0);
                                c1_next = bmp565_pkg::WIN_W'(fc1);
                                r0_next = bmp565_pkg::WIN_W'(fr0);
                                r1_next = bmp565_pkg::WIN_W'(fr1);
                                offx_next = mode_reg ? 16'd0 : latx_reg;
                                offy_next = mode_reg ? 16'd0 : laty_reg;
                                lastf_next = DW'(flast);
                                rb_next = fh_rb;
                                mono_next = (fh_depth == 16'd1);
                            end
                        end
                    end
                    PH_PRE, PH_DATA:
                    begin
                        if ((phase_reg == PH_PRE) && (pos_reg != off_reg))
                        begin
                            pos_next = pos_reg + 32'd1;
                        end
                        else
                        begin
                            push = d_push;
                            push_data.kind = mono_reg ? bmp565_pkg::ENT_MONO
                                                      : bmp565_pkg::ENT_RGB;
                            push_data.done = d_fin;
                            push_data.x = px;
                            push_data.y = 12'(rowr) + offy_reg[11:0];
                            push_data.color = bmp565_pkg::to565(file_byte, part_reg[15:8],
                                                                part_reg[7:0]);
                            push_data.bits = file_byte;
                            push_data.mask = mmask;
                            push_data.raw = mode_reg;
                            push_data.pal0 = pal0_reg;
                            push_data.pal1 = pal1_reg;
                            if (!mono_reg && rgb_rng)
                            begin
                                if (k_e == 2'd0) part_next[7:0] = file_byte;
                                if (k_e == 2'd1) part_next[15:8] = file_byte;
                            end
                            if (d_fin)
                            begin
                                phase_next = PH_WAIT;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                if (wrap)
                                begin
                                    bir_next = '0;
                                    row_next = row_e + DW'(1);
                                    col_next = '0;
                                    k_next = 2'd0;
                                end
                                else
                                begin
                                    bir_next = RBW'(bir_inc);
                                    row_next = row_e;
                                    if (mono_reg)
                                    begin
                                        col_next = col_e + CW'(8);
                                        k_next = k_e;
                                    end
                                    else if (rgb_rng)
                                    begin
                                        col_next = (k_e == 2'd2) ? col_e + CW'(1) : col_e;
                                        k_next = (k_e == 2'd2) ? 2'd0 : k_e + 2'd1;
                                    end
                                    else
                                    begin
                                        col_next = col_e;
                                        k_next = k_e;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;     acc_reg <= acc_next;     sig_reg <= sig_next;
        off_reg <= off_next;     hdr_reg <= hdr_next;     wid_reg <= wid_next;
        hgt_reg <= hgt_next;     bu_reg <= bu_next;       depth_reg <= depth_next;
        planes_reg <= planes_next; comp_reg <= comp_next;
        pal0_reg <= pal0_next;   pal1_reg <= pal1_next;   mode_reg <= mode_next;
        latx_reg <= latx_next;   laty_reg <= laty_next;
        latsw_reg <= latsw_next; latsh_reg <= latsh_next;
        c0_reg <= c0_next;  c1_reg <= c1_next;  r0_reg <= r0_next;  r1_reg <= r1_next;
        offx_reg <= offx_next;   offy_reg <= offy_next;   lastf_reg <= lastf_next;
        rb_reg <= rb_next;       mono_reg <= mono_next;   row_reg <= row_next;
        bir_reg <= bir_next;     col_reg <= col_next;     k_reg <= k_next;
        part_reg <= part_next;
    end

endmodule

/* sv/bmp565_back.sv */
// ----------------------------------------------------------------------------
// bmp565_back
// Turns queued requests into results: one pixel or status per cycle while
// not stalled; mono bytes expand bit by bit into a stallable output register.
// ----------------------------------------------------------------------------
module bmp565_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bmp565_pkg::entry_t  head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                pixel_valid,
    output logic [11:0]         pixel_x,
    output logic [11:0]         pixel_y,
    output logic [15:0]         color,
    output logic                status,
    output logic                done_res
);

    logic        ov_reg, ov_next;
    logic [7:0]  served_reg, served_next;
    logic        pv_reg, pv_next, st_reg, st_next, dn_reg, dn_next;
    logic [11:0] x_reg, x_next, y_reg, y_next;
    logic [15:0] c_reg, c_next;
    logic        ofree, bitv;
    logic [7:0]  rem, sel_oh, rem_left;
    logic [2:0]  sel;

    always_comb
    begin
        ofree = !ov_reg || !out_stall;
        rem   = head.mask & ~served_reg;
        sel   = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (rem[k])
            begin
                sel = 3'(k);
            end
        end
        sel_oh   = 8'd1 << sel;
        rem_left = rem & ~sel_oh;
        bitv     = head.bits[3'd7 - sel];

        ov_next = ov_reg && out_stall;
        served_next = served_reg;
        pv_next = pv_reg;  st_next = st_reg;  dn_next = dn_reg;
        x_next = x_reg;    y_next = y_reg;    c_next = c_reg;
        pop = 1'b0;

        if (head_valid && ofree)
        begin
            ov_next = 1'b1;
            unique case (head.kind)
                bmp565_pkg::ENT_RGB:
                begin
                    pop = 1'b1;
                    pv_next = 1'b1;  st_next = 1'b0;  dn_next = head.done;
                    x_next = head.x; y_next = head.y; c_next = head.color;
                end
                bmp565_pkg::ENT_MONO:
                begin
                    pv_next = 1'b1;  st_next = 1'b0;
                    dn_next = head.done && (rem_left == 8'd0);
                    x_next = head.x + 12'(sel);
                    y_next = head.y;
                    if (head.raw)
                    begin
                        c_next = {15'd0, bitv};
                    end
                    else
                    begin
                        c_next = bitv ? head.pal1 : head.pal0;
                    end
                    if (rem_left == 8'd0)
                    begin
                        pop = 1'b1;
                        served_next = 8'd0;
                    end
                    else
                    begin
                        served_next = served_reg | sel_oh;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                    pv_next = 1'b0;  st_next = head.status;  dn_next = head.done;
                    x_next = '0;     y_next = '0;            c_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            served_reg <= 8'd0;
        end
        else
        begin
            ov_reg     <= ov_next;
            served_reg <= served_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg <= pv_next;  st_reg <= st_next;  dn_reg <= dn_next;
        x_reg  <= x_next;   y_reg  <= y_next;   c_reg  <= c_next;
    end

    assign out_valid   = ov_reg;
    assign pixel_valid = pv_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign color       = c_reg;
    assign status      = st_reg;
    assign done_res    = dn_reg;

endmodule

/* sv/bmp565_checker.sv */
// ----------------------------------------------------------------------------
// bmp565_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp_stream_to_rgb565_decoder_macros.svh"

module bmp565_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        pixel_valid,
    input logic [11:0] pixel_x,
    input logic [11:0] pixel_y,
    input logic [15:0] color,
    input logic        status,
    input logic        done_res
);

    // stalled result holds
    `BMP565_ASSERT_NXT(a_hold, out_valid && out_stall,
        out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(color)
        && $stable(done_res))

    // status-only results carry no coordinates or color
    `BMP565_ASSERT_IMP(a_status_zero, out_valid && !pixel_valid,
        pixel_x == 12'd0 && pixel_y == 12'd0 && color == 16'd0)

    // pixels always report success
    `BMP565_ASSERT_IMP(a_pixel_ok, out_valid && pixel_valid, !status)

    // a format error always ends the file
    `BMP565_ASSERT_IMP(a_err_done, out_valid && status, done_res)

endmodule

bind bmp_stream_to_rgb565_decoder bmp565_checker u_bmp565_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .color       (color),
    .status      (status),
    .done_res    (done_res)
);

/* verif/bmp_stream_to_rgb565_decoder_tb.sv */
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_decoder_tb
// Self-checking bench: builds small BMP files, streams them byte by byte with
// random idling on both channels, and checks every pixel or status result
// against an in-bench model of the parser, crop window and palette logic.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb565_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD      = 4096;
    localparam int LIMIT     = 600000;   // cycles, far beyond the slowest run
    localparam int RAND_REQS = 90;

    typedef enum int { P_WAIT, P_HEAD, P_PRE, P_DATA } phase_e;
    typedef enum int { E_NONE, E_SIG, E_PLANES, E_COMP, E_DEPTH, E_OFFSET } fault_e;

    typedef struct {
        bit        v;
        bit [11:0] x;
        bit [11:0] y;
        bit [15:0] c;
        bit        s;
        bit        d;
    } pix_t;

    // one directed file: format, fault, register setting, truncation, typed result
    typedef struct {
        int     depth;
        int     w;
        int     h;
        int     hdr;
        fault_e flt;
        bit     mode;
        int     dx;
        int     dy;
        int     sw;
        int     sh;
        int     cut;     // 0 = whole file
        bit     typed;   // expected single status result typed in below
        bit     tstat;
    } file_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [bmp565_pkg::REG_IDX_W-1:0] wr_index = '0;
    logic [bmp565_pkg::CFG_DW-1:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] file_byte = '0;
    logic first_byte = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic pixel_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] color;
    logic status;
    logic done_res;

    bmp_stream_to_rgb565_decoder #(.MAX_DIM(MAXD)) u_top (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .file_byte(file_byte), .first_byte(first_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_valid(pixel_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .color(color), .status(status), .done_res(done_res)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------
    logic [15:0] r_dx = 16'd0, r_dy = 16'd0;
    logic [12:0] r_sw = 13'd320, r_sh = 13'd240;
    logic        r_mode = 1'b0;

    phase_e      ph = P_WAIT;
    int unsigned bpos, acc, doff, hsz, iw, ih, depth, planes, comp, sig;
    bit          bup = 1'b1;
    int unsigned row, bir, part, last_f, row_bytes;
    logic [15:0] pal [2] = '{16'd0, 16'd0};
    bit          l_mode;
    longint      l_x, l_y, l_sw, l_sh, wc0, wc1, wr0, wr1, ox, oy;
    bit          fin;
    bit          mute;          // typed rows supply their own expectation

    pix_t        pending_pix[$];

    int  snd_idle = 35, rcv_idle = 52;
    int  n_reqs, n_res, n_err, n_files;
    int  cycles;
    logic [7:0] file_q[$];

    // Register index per position in set_regs().
    localparam logic [bmp565_pkg::REG_IDX_W-1:0] REG_IDS [5] = '{
        bmp565_pkg::REG_DEST_X, bmp565_pkg::REG_DEST_Y,
        bmp565_pkg::REG_SCREEN_WIDTH, bmp565_pkg::REG_SCREEN_HEIGHT,
        bmp565_pkg::REG_OUTPUT_MODE};

    function automatic void push_result(bit v, longint x, longint y, int unsigned c,
                                        bit s, bit d);
        pix_t p;
        if (mute)
            return;
        p.v = v; p.x = x[11:0]; p.y = y[11:0]; p.c = c[15:0]; p.s = s; p.d = d;
        pending_pix.push_back(p);
    endfunction

    // Palette bytes are taken from 14 + header size, but never before byte 18.
    function automatic void grab_palette(int unsigned p, logic [7:0] b);
        longint base, d;
        int k;
        base = 14 + longint'(hsz);
        if (p < 18 || longint'(p) < base)
            return;
        d = longint'(p) - base;
        if (d >= 8)
            return;
        k = int'(d >> 2);
        case (d & 3)
            0: pal[k][4:0]   = b[7:3];
            1: pal[k][10:5]  = b[7:2];
            2: pal[k][15:11] = b[7:3];
            default: ;
        endcase
    endfunction

    function automatic void close_header(int unsigned p);
        longint need, lw, lh, x0, y0;
        bit bad;
        need = 14 + longint'(hsz) + (depth == 1 ? 8 : 0);
        if (need < longint'(p) + 1)
            need = longint'(p) + 1;
        bad = (sig != bmp565_pkg::BMP_SIGNATURE) || (planes != 1) || (comp != 0) ||
              (depth != 1 && depth != 24) || (iw > MAXD) || (ih > MAXD) ||
              (longint'(doff) < need);
        if (bad) begin
            ph = P_WAIT;
            push_result(0, 0, 0, 0, 1, 1);
            return;
        end
        if (!l_mode) begin
            wc0 = l_x < 0 ? -l_x : 0;
            x0  = l_x < 0 ? 0 : l_x;
            lw  = longint'(iw) - wc0;
            if (x0 + lw > l_sw)
                lw = l_sw - x0;
            wr0 = l_y < 0 ? -l_y : 0;
            y0  = l_y < 0 ? 0 : l_y;
            lh  = longint'(ih) - wr0;
            if (y0 + lh > l_sh)
                lh = l_sh - y0;
            ox = l_x;
            oy = l_y;
        end
        else begin
            wc0 = 0; wr0 = 0; lw = iw; lh = ih; ox = 0; oy = 0;
        end
        if (lw <= 0 || lh <= 0) begin
            ph = P_WAIT;
            push_result(0, 0, 0, 0, 0, 1);
            return;
        end
        wc1 = wc0 + lw - 1;
        wr1 = wr0 + lh - 1;
        last_f = bup ? ih - 1 - int'(wr0) : int'(wr1);
        row_bytes = ((depth * iw + 31) / 32) * 4;
        ph = P_PRE;
    endfunction

    function automatic void emit_pixel(longint c, int unsigned col);
        longint r;
        bit d;
        r = bup ? longint'(ih) - 1 - longint'(row) : longint'(row);
        if (c < wc0 || c > wc1 || r < wr0 || r > wr1)
            return;
        d = (row == last_f) && (c == wc1);
        if (d)
            fin = 1'b1;
        push_result(1, c + ox, r + oy, col, 0, d);
    endfunction

    function automatic void pixel_byte(logic [7:0] b);
        int unsigned bb, c;
        logic [15:0] pc;
        fin = 1'b0;
        bb = bir;
        if (depth == 24) begin
            if (longint'(bb) < 3 * longint'(iw)) begin
                case (bb % 3)
                    0: part = b;
                    1: part = (part & 32'hFF) | (int'(b) << 8);
                    default: begin
                        pc = {b[7:3], part[15:10], part[7:3]};
                        emit_pixel(bb / 3, pc);
                    end
                endcase
            end
        end
        else begin
            for (int i = 0; i < 8 && !fin; i++) begin
                c = bb * 8 + i;
                if (c >= iw)
                    break;
                emit_pixel(c, l_mode ? int'(b[7-i]) : int'(pal[b[7-i]]));
            end
        end
        if (fin) begin
            ph = P_WAIT;
            return;
        end
        bir = bb + 1;
        if (bir >= row_bytes) begin
            bir = 0;
            row++;
        end
    endfunction

    // Advance the model by one accepted byte request.
    function automatic void decode_byte(logic [7:0] b, bit first);
        int unsigned p, a;
        if (first) begin
            l_mode = r_mode;
            l_x = longint'($signed(r_dx));
            l_y = longint'($signed(r_dy));
            l_sw = r_sw;
            l_sh = r_sh;
            bpos = 0; acc = 0; doff = 0; hsz = 0; iw = 0; ih = 0; bup = 1;
            depth = 0; planes = 0; comp = 0; row = 0; bir = 0; part = 0; sig = 0;
            ph = P_HEAD;
            // window off screen: one status result, rest of file ignored
            if (!l_mode && (l_x >= l_sw || l_y >= l_sh)) begin
                ph = P_WAIT;
                push_result(0, 0, 0, 0, 0, 1);
                return;
            end
        end
        if (ph == P_HEAD) begin
            p = bpos;
            grab_palette(p, b);
            a = {b, acc[31:8]};
            acc = a;
            bpos = p + 1;
            case (p)
                1:  sig = a >> 16;
                13: doff = a;
                17: hsz = a;
                21: iw = a;
                25: begin
                    if (a[31]) begin
                        ih = ~a + 1; bup = 0;
                    end
                    else begin
                        ih = a; bup = 1;
                    end
                end
                27: planes = a >> 16;
                29: begin
                    depth = a >> 16;
                    if (hsz <= 12)
                        close_header(p);
                end
                33: comp = a;
                53: close_header(p);
                default: ;
            endcase
            return;
        end
        if (ph == P_PRE) begin
            if (bpos != doff) begin
                grab_palette(bpos, b);
                bpos++;
                return;
            end
            ph = P_DATA;
            row = 0;
            bir = 0;
        end
        if (ph == P_DATA)
            pixel_byte(b);
    endfunction

    // ------------------------------------------------------------------
    // File builder
    // ------------------------------------------------------------------
    function automatic void put_le(int pos, int unsigned v, int nb);
        for (int i = 0; i < nb; i++)
            file_q[pos+i] = 8'(v >> (8 * i));
    endfunction

    function automatic void build_file(int dep, int w, int h, int hdr, fault_e flt);
        int hend, off, rb, n, habs, dp;
        hend = hdr > 12 ? 54 : 30;
        dp = (flt == E_DEPTH) ? 8 : dep;
        off = 14 + hdr + (dp == 1 ? 8 : 0);
        if (off < hend)
            off = hend;
        if (flt == E_OFFSET)
            off = off - 1;
        else
            off = off + $urandom_range(2);
        habs = h < 0 ? -h : h;
        rb = ((dp * w + 31) / 32) * 4;
        n = off + rb * habs;
        file_q.delete();
        for (int i = 0; i < n; i++)
            file_q.push_back(8'($urandom_range(255)));
        put_le(0, (flt == E_SIG) ? 16'h4D43 : bmp565_pkg::BMP_SIGNATURE, 2);
        put_le(2, n, 4);
        put_le(10, off, 4);
        put_le(14, hdr, 4);
        put_le(18, w, 4);
        put_le(22, h, 4);
        put_le(26, (flt == E_PLANES) ? 2 : 1, 2);
        put_le(28, dp, 2);
        if (hdr > 12)
            put_le(30, (flt == E_COMP) ? 1 : 0, 4);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, bit f);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        file_byte  <= b;
        first_byte <= f;
        do @(posedge clk); while (in_stall);
        decode_byte(b, f);
        n_reqs++;
    endtask

    task automatic send_file(int cut);
        int n;
        n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
        for (int i = 0; i < n; i++)
            send_byte(file_q[i], i == 0);
        n_files++;
    endtask

    // Block idle: all results back, then an idle wait so queued empty work drains.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pix.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_regs(int dx, int dy, int sw, int sh, bit mode);
        logic [bmp565_pkg::CFG_DW-1:0] vals [5];
        vals = '{bmp565_pkg::CFG_DW'(dx), bmp565_pkg::CFG_DW'(dy),
                 bmp565_pkg::CFG_DW'(sw), bmp565_pkg::CFG_DW'(sh),
                 bmp565_pkg::CFG_DW'(mode)};
        for (int i = 0; i < 5; i++) begin
            wr_en    <= 1'b1;
            wr_index <= REG_IDS[i];
            wr_data  <= vals[i];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        r_dx = 16'(dx); r_dy = 16'(dy); r_sw = 13'(sw); r_sh = 13'(sh); r_mode = mode;
    endtask

    // ------------------------------------------------------------------
    // Result checker and output stall
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        pix_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                n_res++;
                if (pending_pix.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result x=%0d y=%0d c=%h s=%0b d=%0b",
                                 pixel_x, pixel_y, color, status, done_res);
                end
                else begin
                    e = pending_pix.pop_front();
                    if (pixel_valid !== e.v || pixel_x !== e.x || pixel_y !== e.y ||
                        color !== e.c || status !== e.s || done_res !== e.d) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp %0b %0d %0d %h %0b %0b, got %0b",
                                     e.v, e.x, e.y, e.c, e.s, e.d, pixel_valid);
                        if (n_err <= 10)
                            $display("  got x %0d y %0d c %h s %0b d %0b",
                                     pixel_x, pixel_y, color, status, done_res);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    file_row_t rows [7] = '{
        // depth w     h      hdr flt       md dx      dy      sw    sh   cut typ st
        '{1,    9,    2,     40, E_NONE,   0, 0,      0,      320,  240, 0,  0, 0},
        '{24,   3,    -2,    12, E_NONE,   0, 2,      1,      320,  240, 0,  0, 0},
        '{24,   2,    2,     12, E_SIG,    0, 0,      0,      320,  240, 30, 1, 1},
        '{24,   4097, 1,     12, E_NONE,   1, 0,      0,      320,  240, 30, 1, 1},
        '{1,    4,    2,     12, E_OFFSET, 0, 0,      0,      320,  240, 30, 1, 1},
        '{24,   2,    2,     40, E_NONE,   0, 320,    0,      320,  240, 2,  1, 0},
        '{24,   2,    2,     12, E_NONE,   0, -32768, 0,      4096, 4096, 30, 1, 0}
    };

    initial begin
        int dep, w, h, hdr, cut;
        fault_e flt;
        pix_t tp;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed files
        foreach (rows[i]) begin
            drain();
            set_regs(rows[i].dx, rows[i].dy, rows[i].sw, rows[i].sh, rows[i].mode);
            build_file(rows[i].depth, rows[i].w, rows[i].h, rows[i].hdr, rows[i].flt);
            mute = rows[i].typed;
            if (rows[i].typed) begin
                tp = '{0, 0, 0, 0, rows[i].tstat, 1};
                pending_pix.push_back(tp);
            end
            send_file(rows[i].cut);
            mute = 1'b0;
        end

        // random files in three idling phases
        for (int ph_i = 0; ph_i < 3; ph_i++) begin
            snd_idle = (ph_i == 0) ? 35 : (ph_i == 1) ? 52 : 0;
            rcv_idle = (ph_i == 0) ? 52 : (ph_i == 1) ? 35 : 0;
            n_reqs = 0;
            while (n_reqs < RAND_REQS / 3) begin
                drain();
                if ($urandom_range(5) == 0)
                    set_regs($urandom_range(1) ? -32768 : 32767, $urandom_range(3) - 1,
                             $urandom_range(1) ? 4096 : 1, $urandom_range(8) + 1, 0);
                else
                    set_regs(int'($urandom_range(8)) - 3, int'($urandom_range(8)) - 3,
                             $urandom_range(1) ? 320 : $urandom_range(8) + 1,
                             $urandom_range(1) ? 240 : $urandom_range(8) + 1,
                             $urandom_range(1));
                dep = $urandom_range(1) ? 24 : 1;
                hdr = $urandom_range(3) == 0 ? 40 : 12;
                w = (dep == 1 && $urandom_range(3) == 0) ? 33 : $urandom_range(7);
                h = $urandom_range(2) + 1;
                if ($urandom_range(1))
                    h = -h;
                flt = ($urandom_range(7) == 0) ? fault_e'($urandom_range(5)) : E_NONE;
                build_file(dep, w, h, hdr, flt);
                // broken sequence: cut short, then restarted by the next file
                cut = ($urandom_range(9) == 0) ? $urandom_range(file_q.size()) : 0;
                send_file(cut);
                // stray bytes after a finished file
                if ($urandom_range(3) == 0 && cut == 0)
                    repeat ($urandom_range(3) + 1)
                        send_byte(8'($urandom_range(255)), 1'b0);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d files (1-bit and 24-bit, both modes, crop, faults, restarts)",
                 n_files);
        $display("%0d results checked, %0d failures, %0d cycles", n_res, n_err, cycles);
        if (n_err == 0 && pending_pix.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
